[src/wss_pkg.sv]
// shared types, constants and command codes for the windowed sample statistics block
package wss_pkg;

    localparam int VAL_W           = 16;
    localparam int TIME_W          = 20;
    localparam int MAX_SAMPLES_DEF = 64;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_STOP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_SELECT = 2'd2;

    localparam logic [TIME_W-1:0] WINDOW_START_RST = 20'h00000;
    localparam logic [TIME_W-1:0] WINDOW_STOP_RST  = 20'hFFFFF;
    localparam logic              FIELD_SELECT_RST = 1'b1;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_MUL_INIT_A,
        OP_MUL_INIT_B,
        OP_MUL_INIT_C,
        OP_MUL_STEP,
        OP_DIV_INIT_MEAN,
        OP_DIV_INIT_VAR,
        OP_DIV_STEP,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   accum;
    } dp_cmd_t;

endpackage

[src/wss_if.sv]
// handshake channel interfaces: samples, results and configuration writes
interface wss_sample_if;
    logic                        valid;
    logic                        ready;
    logic [wss_pkg::TIME_W-1:0]  sample_time;
    logic [wss_pkg::VAL_W-1:0]   first_value;
    logic [wss_pkg::VAL_W-1:0]   second_value;
    logic                        last_sample;

    modport source (output valid, sample_time, first_value, second_value, last_sample,
                    input ready);
    modport sink   (input valid, sample_time, first_value, second_value, last_sample,
                    output ready);
endinterface

interface wss_result_if #(parameter int CNT_W = $clog2(wss_pkg::MAX_SAMPLES_DEF + 1));
    logic                      valid;
    logic                      ready;
    logic [wss_pkg::VAL_W-1:0] mean_value;
    logic [wss_pkg::VAL_W-1:0] std_dev;
    logic                      std_dev_valid;
    logic [wss_pkg::VAL_W-1:0] min_value;
    logic [wss_pkg::VAL_W-1:0] max_value;
    logic [CNT_W-1:0]          sample_count;

    modport source (output valid, mean_value, std_dev, std_dev_valid, min_value, max_value,
                    sample_count, input ready);
    modport sink   (input valid, mean_value, std_dev, std_dev_valid, min_value, max_value,
                    sample_count, output ready);
endinterface

interface wss_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [wss_pkg::CFG_IDX_W-1:0]  index;
    logic [wss_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[src/windowed_sample_statistics_core.sv]
// top level of the windowed sample statistics block
//
//  channel   modport  dir  carries
//  -------   -------  ---  ---------------------------------------------------------
//  cfg       sink     in   register index and write data (start, stop, field select)
//  samples   sink     in   sample_time, first_value, second_value, last_sample
//  results   source   out  mean, std dev and its valid flag, min, max, sample count
//
//  samples are taken one per cycle while the block accumulates
//  an item with last_sample set starts the result sequence; samples are held off
//  while it runs on the shared shift-add multiplier, the restoring divider and the
//  root unit
//  the result sits in an output register; new samples flow meanwhile, and only a
//  second finished result waits for the first to be taken
//  cfg is always ready; rst_n clears control state and accumulators at once
module windowed_sample_statistics_core #(
    parameter int MAX_SAMPLES = wss_pkg::MAX_SAMPLES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    wss_cfg_if.sink       cfg,
    wss_sample_if.sink    samples,
    wss_result_if.source  results
);
    import wss_pkg::*;

    dp_cmd_t cmd;

    // configuration writes take effect in the next cycle
    assign cfg.ready = 1'b1;

    // sequencing: accumulate, then multiply, divide and square root phases
    wss_ctrl #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_last   (samples.last_sample),
        .in_ready  (samples.ready),
        .out_ready (results.ready),
        .out_valid (results.valid),
        .cmd       (cmd)
    );

    // all arithmetic and the result register
    wss_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_we        (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .sample_time   (samples.sample_time),
        .first_value   (samples.first_value),
        .second_value  (samples.second_value),
        .mean_value    (results.mean_value),
        .std_dev       (results.std_dev),
        .std_dev_valid (results.std_dev_valid),
        .min_value     (results.min_value),
        .max_value     (results.max_value),
        .sample_count  (results.sample_count)
    );

endmodule

[src/wss_ctrl.sv]
// controller state machine: accumulate phase and the result computation sequence
module wss_ctrl #(
    parameter int MAX_SAMPLES = wss_pkg::MAX_SAMPLES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_last,
    output logic             in_ready,
    input  logic             out_ready,
    output logic             out_valid,
    output wss_pkg::dp_cmd_t cmd
);
    import wss_pkg::*;

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int LOG_W  = $clog2(MAX_SAMPLES);
    localparam int SUM_W  = VAL_W + LOG_W;
    localparam int NUM_W  = 2 * SUM_W;
    localparam int STEP_W = $clog2(NUM_W + 1);

    typedef enum logic [8:0] {
        ST_ACCUM  = 9'b000000001,
        ST_START  = 9'b000000010,
        ST_MUL_A  = 9'b000000100,
        ST_MUL_B  = 9'b000001000,
        ST_MUL_C  = 9'b000010000,
        ST_DIV_M  = 9'b000100000,
        ST_DIV_V  = 9'b001000000,
        ST_SQRT   = 9'b010000000,
        ST_FINISH = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   steps_reg, steps_next;
    logic                out_valid_reg, out_valid_next;
    logic                in_fire;
    logic                steps_left;

    assign in_ready   = (state_reg == ST_ACCUM);
    assign in_fire    = in_valid && in_ready;
    assign out_valid  = out_valid_reg;
    assign steps_left = (steps_reg != '0);

    always_comb
    begin
        state_next     = state_reg;
        steps_next     = steps_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_NONE;
        cmd.accum      = in_fire;
        unique case (state_reg)
            ST_ACCUM:
            begin
                if (in_fire && in_last)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                cmd.op     = OP_MUL_INIT_A;
                steps_next = STEP_W'(CNT_W);
                state_next = ST_MUL_A;
            end
            ST_MUL_A:
            begin
                if (steps_left)
                begin
                    cmd.op     = OP_MUL_STEP;
                    steps_next = steps_reg - 1'b1;
                end
                else
                begin
                    cmd.op     = OP_MUL_INIT_B;
                    steps_next = STEP_W'(SUM_W);
                    state_next = ST_MUL_B;
                end
            end
            ST_MUL_B:
            begin
                if (steps_left)
                begin
                    cmd.op     = OP_MUL_STEP;
                    steps_next = steps_reg - 1'b1;
                end
                else
                begin
                    cmd.op     = OP_MUL_INIT_C;
                    steps_next = STEP_W'(CNT_W);
                    state_next = ST_MUL_C;
                end
            end
            ST_MUL_C:
            begin
                if (steps_left)
                begin
                    cmd.op     = OP_MUL_STEP;
                    steps_next = steps_reg - 1'b1;
                end
                else
                begin
                    cmd.op     = OP_DIV_INIT_MEAN;
                    steps_next = STEP_W'(SUM_W);
                    state_next = ST_DIV_M;
                end
            end
            ST_DIV_M:
            begin
                if (steps_left)
                begin
                    cmd.op     = OP_DIV_STEP;
                    steps_next = steps_reg - 1'b1;
                end
                else
                begin
                    cmd.op     = OP_DIV_INIT_VAR;
                    steps_next = STEP_W'(NUM_W);
                    state_next = ST_DIV_V;
                end
            end
            ST_DIV_V:
            begin
                if (steps_left)
                begin
                    cmd.op     = OP_DIV_STEP;
                    steps_next = steps_reg - 1'b1;
                end
                else
                begin
                    cmd.op     = OP_SQRT_INIT;
                    steps_next = STEP_W'(VAL_W);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (steps_left)
                begin
                    cmd.op     = OP_SQRT_STEP;
                    steps_next = steps_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // wait here while the previous result is still unread
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_FINISH;
                    out_valid_next = 1'b1;
                    state_next     = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            steps_reg     <= steps_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[src/wss_datapath.sv]
// datapath: config registers, accumulators, shift-add multiplier, divider, square root
module wss_datapath #(
    parameter int MAX_SAMPLES = wss_pkg::MAX_SAMPLES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  wss_pkg::dp_cmd_t                   cmd,
    input  logic                               cfg_we,
    input  logic [wss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wss_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [wss_pkg::TIME_W-1:0]         sample_time,
    input  logic [wss_pkg::VAL_W-1:0]          first_value,
    input  logic [wss_pkg::VAL_W-1:0]          second_value,
    output logic [wss_pkg::VAL_W-1:0]          mean_value,
    output logic [wss_pkg::VAL_W-1:0]          std_dev,
    output logic                               std_dev_valid,
    output logic [wss_pkg::VAL_W-1:0]          min_value,
    output logic [wss_pkg::VAL_W-1:0]          max_value,
    output logic [$clog2(MAX_SAMPLES + 1)-1:0] sample_count
);
    import wss_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int LOG_W = $clog2(MAX_SAMPLES);
    localparam int SUM_W = VAL_W + LOG_W;
    localparam int SQ_W  = 2 * VAL_W + LOG_W;
    localparam int NUM_W = 2 * SUM_W;
    localparam int DEN_W = 2 * CNT_W;
    localparam int RAD_W = 2 * VAL_W;

    // configuration
    logic [TIME_W-1:0] window_start_reg;
    logic [TIME_W-1:0] window_stop_reg;
    logic              field_select_reg;

    // accumulators
    logic [CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SQ_W-1:0]  sq_reg;
    logic [VAL_W-1:0] min_reg;
    logic [VAL_W-1:0] max_reg;

    // working registers
    logic [NUM_W-1:0] prod_reg;
    logic [NUM_W-1:0] mcand_reg;
    logic [SUM_W-1:0] mplier_reg;
    logic [NUM_W-1:0] a_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] div_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [VAL_W-1:0] mean_reg;
    logic [RAD_W-1:0] rad_reg;
    logic [VAL_W+1:0] srem_reg;
    logic [VAL_W-1:0] root_reg;

    // result registers
    logic [VAL_W-1:0] res_mean_reg;
    logic [VAL_W-1:0] res_sd_reg;
    logic             res_sd_valid_reg;
    logic [VAL_W-1:0] res_min_reg;
    logic [VAL_W-1:0] res_max_reg;
    logic [CNT_W-1:0] res_cnt_reg;

    logic [VAL_W-1:0]   sel_value;
    logic [2*VAL_W-1:0] sel_sq;
    logic               hit;
    logic [DEN_W:0]     div_sh;
    logic               div_ge;
    logic [VAL_W+1:0]   sq_sh;
    logic [VAL_W+1:0]   sq_trial;
    logic               sq_ge;
    logic               cnt_ge2;

    assign sel_value = field_select_reg ? second_value : first_value;
    // full width square of the measured value
    assign sel_sq    = sel_value * sel_value;
    assign hit = (sample_time > window_start_reg) && (sample_time < window_stop_reg)
              && (cnt_reg < CNT_W'(MAX_SAMPLES));

    // restoring division step
    assign div_sh = {rem_reg, quo_reg[NUM_W-1]};
    assign div_ge = (div_sh >= {1'b0, div_reg});

    // square root digit step
    assign sq_sh    = {srem_reg[VAL_W-1:0], rad_reg[RAD_W-1 -: 2]};
    assign sq_trial = {root_reg, 2'b01};
    assign sq_ge    = (sq_sh >= sq_trial);

    assign cnt_ge2 = (cnt_reg >= CNT_W'(2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_start_reg <= WINDOW_START_RST;
            window_stop_reg  <= WINDOW_STOP_RST;
            field_select_reg <= FIELD_SELECT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WINDOW_START: window_start_reg <= cfg_data[TIME_W-1:0];
                REG_WINDOW_STOP:  window_stop_reg  <= cfg_data[TIME_W-1:0];
                REG_FIELD_SELECT: field_select_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sum_reg <= '0;
            sq_reg  <= '0;
            min_reg <= '0;
            max_reg <= '0;
        end
        else if (cmd.op == OP_FINISH)
        begin
            cnt_reg <= '0;
            sum_reg <= '0;
            sq_reg  <= '0;
            min_reg <= '0;
            max_reg <= '0;
        end
        else if (cmd.accum && hit)
        begin
            if (cnt_reg == '0)
            begin
                min_reg <= sel_value;
                max_reg <= sel_value;
            end
            else
            begin
                if (sel_value < min_reg)
                begin
                    min_reg <= sel_value;
                end
                if (sel_value > max_reg)
                begin
                    max_reg <= sel_value;
                end
            end
            cnt_reg <= cnt_reg + 1'b1;
            sum_reg <= sum_reg + SUM_W'(sel_value);
            sq_reg  <= sq_reg + SQ_W'(sel_sq);
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_MUL_INIT_A:
            begin
                prod_reg   <= '0;
                mcand_reg  <= NUM_W'(sq_reg);
                mplier_reg <= SUM_W'(cnt_reg);
            end
            OP_MUL_INIT_B:
            begin
                a_reg      <= prod_reg;
                prod_reg   <= '0;
                mcand_reg  <= NUM_W'(sum_reg);
                mplier_reg <= sum_reg;
            end
            OP_MUL_INIT_C:
            begin
                a_reg      <= a_reg - prod_reg;
                prod_reg   <= '0;
                mcand_reg  <= NUM_W'(cnt_reg);
                mplier_reg <= SUM_W'(cnt_reg - 1'b1);
            end
            OP_MUL_STEP:
            begin
                if (mplier_reg[0])
                begin
                    prod_reg <= prod_reg + mcand_reg;
                end
                mcand_reg  <= {mcand_reg[NUM_W-2:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[SUM_W-1:1]};
            end
            OP_DIV_INIT_MEAN:
            begin
                den_reg <= prod_reg[DEN_W-1:0];
                div_reg <= DEN_W'(cnt_reg);
                rem_reg <= '0;
                quo_reg <= {sum_reg, {(NUM_W - SUM_W){1'b0}}};
            end
            OP_DIV_INIT_VAR:
            begin
                mean_reg <= quo_reg[VAL_W-1:0];
                div_reg  <= den_reg;
                rem_reg  <= '0;
                quo_reg  <= a_reg;
            end
            OP_DIV_STEP:
            begin
                rem_reg <= div_ge ? DEN_W'(div_sh - {1'b0, div_reg}) : div_sh[DEN_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], div_ge};
            end
            OP_SQRT_INIT:
            begin
                rad_reg  <= quo_reg[RAD_W-1:0];
                srem_reg <= '0;
                root_reg <= '0;
            end
            OP_SQRT_STEP:
            begin
                srem_reg <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
                root_reg <= {root_reg[VAL_W-2:0], sq_ge};
                rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            end
            OP_FINISH:
            begin
                res_mean_reg     <= (cnt_reg != '0) ? mean_reg : '0;
                res_sd_reg       <= cnt_ge2 ? root_reg : '0;
                res_sd_valid_reg <= cnt_ge2;
                res_min_reg      <= min_reg;
                res_max_reg      <= max_reg;
                res_cnt_reg      <= cnt_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign mean_value    = res_mean_reg;
    assign std_dev       = res_sd_reg;
    assign std_dev_valid = res_sd_valid_reg;
    assign min_value     = res_min_reg;
    assign max_value     = res_max_reg;
    assign sample_count  = res_cnt_reg;

endmodule

[src/wss_checker.sv]
// port level checks for the windowed sample statistics block, bound to the top level
module wss_checker #(
    parameter int MAX_SAMPLES = wss_pkg::MAX_SAMPLES_DEF
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               s_last,
    input logic                               r_valid,
    input logic [wss_pkg::VAL_W-1:0]          mean,
    input logic                               sd_valid,
    input logic [wss_pkg::VAL_W-1:0]          min_v,
    input logic [wss_pkg::VAL_W-1:0]          max_v,
    input logic [$clog2(MAX_SAMPLES + 1)-1:0] count
);
    import wss_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

    // a closing item starts the computation, so the block stops taking items
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid && s_ready && s_last |=> !s_ready)
        else $error("sample channel still ready after a closing item");

    a_sd_valid: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid |-> (sd_valid == (count >= CNT_W'(2))))
        else $error("std_dev_valid does not match sample_count");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && (count == '0) |-> (mean == '0) && (min_v == '0) && (max_v == '0))
        else $error("empty window gave nonzero mean, min or max");

    a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid |-> (min_v <= mean) && (mean <= max_v))
        else $error("mean outside min and max");

endmodule

bind windowed_sample_statistics_core wss_checker #(
    .MAX_SAMPLES (MAX_SAMPLES)
) u_wss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_valid  (samples.valid),
    .s_ready  (samples.ready),
    .s_last   (samples.last_sample),
    .r_valid  (results.valid),
    .mean     (results.mean_value),
    .sd_valid (results.std_dev_valid),
    .min_v    (results.min_value),
    .max_v    (results.max_value),
    .count    (results.sample_count)
);
